// ===== design/apof_pkg.sv =====
// ----------------------------------------------------------------------------
// apof_pkg: shared types for the AABB pair overlap finder
// Box record layout and field widths used by the finder and its box store.
// ----------------------------------------------------------------------------
package apof_pkg;

    localparam int COORD_W = 32;
    localparam int INDEX_W = 6;

    // One axis-aligned box, signed Q16.16 corners
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
    } t_box;

    localparam int BOX_W = $bits(t_box);

endpackage

// ===== design/apof_ram.sv =====
// ----------------------------------------------------------------------------
// apof_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module apof_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/aabb_pair_overlap_finder.sv =====
// An accepted box occupies the block through an accept step, one store read per box stored in
// the frame, a compare drain and a store; with no stored boxes the drain is skipped.
// No new box is taken until the current one is stored; output stall pauses the scan.
// A box arriving at a full store is dropped in its accept cycle.
// Reset (synchronous, active low) clears the box count and all control state;
// the box store itself is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
// aabb_pair_overlap_finder: broad-phase 2D box overlap search
// Compares each new box with the frame's stored boxes through one shared
// compare unit fed from the box store, reports overlapping pairs in index
// order with the final pair flagged, then stores the box.
// ----------------------------------------------------------------------------
module aabb_pair_overlap_finder #(
    parameter int MAX_BOXES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input box channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_frame_start,
    input  logic signed [apof_pkg::COORD_W-1:0] i_min_x,
    input  logic signed [apof_pkg::COORD_W-1:0] i_min_y,
    input  logic signed [apof_pkg::COORD_W-1:0] i_max_x,
    input  logic signed [apof_pkg::COORD_W-1:0] i_max_y,
    // output pair channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [apof_pkg::INDEX_W-1:0]        o_new_index,
    output logic [apof_pkg::INDEX_W-1:0]        o_old_index,
    output logic                                o_last_pair
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                        r_state;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              r_rd_idx;
    logic                          r_cmp_valid;
    logic [IDX_W-1:0]              r_cmp_idx;
    logic                          r_pend_valid;
    logic [IDX_W-1:0]              r_pend_idx;
    apof_pkg::t_box                r_box;
    logic                          r_out_valid;
    logic [apof_pkg::INDEX_W-1:0]  r_out_new;
    logic [apof_pkg::INDEX_W-1:0]  r_out_old;
    logic                          r_out_last;

    apof_pkg::t_box                w_stored;
    logic [apof_pkg::BOX_W-1:0]    w_rd_data;
    logic                          w_advance;
    logic                          w_rd_more;
    logic                          w_hit;
    logic                          w_rd_en;
    logic                          w_wr_en;
    logic                          w_emit_mid;
    logic                          w_emit_last;

    // Pause the scan whenever the output register cannot take a transaction
    assign w_advance = !(r_out_valid && i_out_stall);
    assign w_rd_more = (r_rd_idx < r_count);
    assign w_rd_en   = (r_state == S_SCAN) && w_advance && w_rd_more;
    assign w_wr_en   = (r_state == S_SCAN) && w_advance && !w_rd_more && !r_cmp_valid;

    // Release a pair: the older pending hit on a new hit, or the final one at scan end
    assign w_emit_mid  = (r_state == S_SCAN) && w_advance && r_cmp_valid && w_hit &&
                         r_pend_valid;
    assign w_emit_last = w_wr_en && r_pend_valid;

    // Box store
    apof_ram #(
        .WIDTH (apof_pkg::BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (r_box),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Shared overlap compare: both axes, touching edges count
    always_comb begin
        w_stored = apof_pkg::t_box'(w_rd_data);
        w_hit    = (w_stored.min_x <= r_box.max_x) && (r_box.min_x <= w_stored.max_x) &&
                   (w_stored.min_y <= r_box.max_y) && (r_box.min_y <= w_stored.max_y);
    end

    // Sequencer, pending-pair hold and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rd_idx     <= '0;
            r_cmp_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Load a released pair, else drop the output transaction once taken
            if (w_emit_mid || w_emit_last) begin
                r_out_valid <= 1'b1;
                r_out_new   <= apof_pkg::INDEX_W'(r_count);
                r_out_old   <= apof_pkg::INDEX_W'(r_pend_idx);
                r_out_last  <= w_emit_last;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_box.min_x  <= i_min_x;
                        r_box.min_y  <= i_min_y;
                        r_box.max_x  <= i_max_x;
                        r_box.max_y  <= i_max_y;
                        r_rd_idx     <= '0;
                        r_cmp_valid  <= 1'b0;
                        r_pend_valid <= 1'b0;
                        if (i_frame_start) begin
                            r_count <= '0;
                            r_state <= S_SCAN;
                        end else if (r_count < CNT_W'(MAX_BOXES)) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_advance) begin
                        // Hold a hit as pending; the older one leaves as a non-final pair
                        if (r_cmp_valid && w_hit) begin
                            r_pend_valid <= 1'b1;
                            r_pend_idx   <= r_cmp_idx;
                        end
                        if (w_rd_more) begin
                            // Advance to the next stored box
                            r_cmp_valid <= 1'b1;
                            r_cmp_idx   <= r_rd_idx[IDX_W-1:0];
                            r_rd_idx    <= r_rd_idx + 1'b1;
                        end else begin
                            r_cmp_valid <= 1'b0;
                            if (!r_cmp_valid) begin
                                // Scan done: the final pair leaves, store the box
                                r_pend_valid <= 1'b0;
                                r_count      <= r_count + 1'b1;
                                r_state      <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_new_index = r_out_new;
    assign o_old_index = r_out_old;
    assign o_last_pair = r_out_last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the AABB pair overlap finder
// Feeds directed and random box frames through the input channel, predicts
// the overlapping pairs of every accepted box, and checks each pair
// transaction in order. Both channels see random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_BOXES      = 64;
    localparam int RANDOM_ITEMS   = 360;
    localparam int CALM_TAIL      = 40;
    localparam int DRAIN_CYCLES   = MAX_BOXES + 16;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic signed [apof_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [apof_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic           frame_start;
        apof_pkg::t_box box;
    } t_box_item;

    typedef struct packed {
        logic [apof_pkg::INDEX_W-1:0] new_index;
        logic [apof_pkg::INDEX_W-1:0] old_index;
        logic                         last_pair;
    } t_pair;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_in_valid    = 1'b0;
    logic                                i_frame_start = 1'b0;
    logic signed [apof_pkg::COORD_W-1:0] i_min_x       = '0;
    logic signed [apof_pkg::COORD_W-1:0] i_min_y       = '0;
    logic signed [apof_pkg::COORD_W-1:0] i_max_x       = '0;
    logic signed [apof_pkg::COORD_W-1:0] i_max_y       = '0;
    logic                                i_out_stall   = 1'b0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [apof_pkg::INDEX_W-1:0]        o_new_index;
    logic [apof_pkg::INDEX_W-1:0]        o_old_index;
    logic                                o_last_pair;

    // pending boxes, expected pairs and the predicted frame contents
    t_box_item      pending_boxes[$];
    t_pair          expected_pairs[$];
    apof_pkg::t_box frame_boxes[MAX_BOXES];
    int             frame_fill;
    int             boxes_total;
    int             boxes_accepted;
    int             boxes_loaded;
    int             mismatch_count;
    int             quiet_cycles;
    int             in_gap;
    int             out_hold;
    int             idle_odds;
    bit             calm;
    t_box_item      next_box;
    t_pair          oldest_pair;

    aabb_pair_overlap_finder #(
        .MAX_BOXES (MAX_BOXES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_frame_start (i_frame_start),
        .i_min_x       (i_min_x),
        .i_min_y       (i_min_y),
        .i_max_x       (i_max_x),
        .i_max_y       (i_max_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_new_index   (o_new_index),
        .o_old_index   (o_old_index),
        .o_last_pair   (o_last_pair)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Two boxes meet when their ranges overlap on both axes, touching included
    function automatic logic boxes_meet(input apof_pkg::t_box a, input apof_pkg::t_box b);
        return ($signed(a.min_x) <= $signed(b.max_x)) && ($signed(b.min_x) <= $signed(a.max_x))
            && ($signed(a.min_y) <= $signed(b.max_y)) && ($signed(b.min_y) <= $signed(a.max_y));
    endfunction

    // Clear on frame start, drop when full, else list the earlier boxes it meets and record it
    function automatic void predict_pairs(input logic fs, input apof_pkg::t_box nb);
        int    hit_list[$];
        t_pair p;
        if (fs)
            frame_fill = 0;
        if (frame_fill >= MAX_BOXES)
            return;
        for (int k = 0; k < frame_fill; k++) begin
            if (boxes_meet(frame_boxes[k], nb))
                hit_list = {hit_list, k};
        end
        foreach (hit_list[j]) begin
            p.new_index = frame_fill[apof_pkg::INDEX_W-1:0];
            p.old_index = hit_list[j][apof_pkg::INDEX_W-1:0];
            p.last_pair = (j == hit_list.size() - 1);
            expected_pairs = {expected_pairs, p};
        end
        frame_boxes[frame_fill] = nb;
        frame_fill++;
    endfunction

    function automatic void queue_box(input logic fs,
        input logic signed [apof_pkg::COORD_W-1:0] x0, y0, x1, y1);
        t_box_item it;
        it.frame_start = fs;
        it.box         = '{min_x: x0, min_y: y0, max_x: x1, max_y: y1};
        pending_boxes  = {pending_boxes, it};
    endfunction

    // Well-formed box, min corner inside +/- 2^span_log, sides below 2^(span_log-1)
    function automatic apof_pkg::t_box random_box(input int span_log);
        apof_pkg::t_box b;
        b.min_x = $signed($urandom) >>> (31 - span_log);
        b.min_y = $signed($urandom) >>> (31 - span_log);
        b.max_x = b.min_x + ($urandom >> (33 - span_log));
        b.max_y = b.min_y + ($urandom >> (33 - span_log));
        return b;
    endfunction

    // Build the stimulus, release reset, wait for the drain, report
    initial begin
        int             frame_len;
        int             span_log;
        int             pick;
        bit             long_done;
        apof_pkg::t_box nb;
        apof_pkg::t_box ref_box;
        apof_pkg::t_box gen_frame[$];
        t_box_item      it;

        // corner touch, near miss, full-range, inverted, points and bit patterns
        queue_box(1'b1, 0, 0, 10, 10);
        queue_box(1'b0, 10, 10, 20, 20);
        queue_box(1'b0, 11, -5, 30, 9);
        queue_box(1'b0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        queue_box(1'b0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        queue_box(1'b0, -1, -1, -1, -1);
        queue_box(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_box(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_box(1'b0, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555);
        queue_box(1'b0, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
        queue_box(1'b0, 20, 0, 40, 10);
        queue_box(1'b1, 5, 5, 5, 5);
        queue_box(1'b1, -100, -100, 100, 100);
        queue_box(1'b0, 100, 100, 200, 200);
        queue_box(1'b0, 101, -200, 150, -101);

        // random frames; one runs past capacity to exercise the drop path
        long_done = 1'b0;
        while (pending_boxes.size() < RANDOM_ITEMS) begin
            if (!long_done && pending_boxes.size() >= RANDOM_ITEMS / 2) begin
                frame_len = MAX_BOXES + $urandom_range(2, 8);
                long_done = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                frame_len = $urandom_range(16, 40);
            end else begin
                frame_len = $urandom_range(1, 12);
            end
            span_log = $urandom_range(3, 30);
            gen_frame.delete();
            for (int n = 0; n < frame_len; n++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    nb = {$urandom, $urandom, $urandom, $urandom};
                end else if (pick <= 4 && gen_frame.size() > 0) begin
                    // sliver on an edge of an earlier box, or one step past it
                    ref_box = gen_frame[$urandom_range(0, gen_frame.size() - 1)];
                    nb      = ref_box;
                    case ($urandom_range(0, 3))
                        0: begin
                            nb.min_x = ref_box.max_x + $urandom_range(0, 1);
                            nb.max_x = nb.min_x;
                        end
                        1: begin
                            nb.max_x = ref_box.min_x - $urandom_range(0, 1);
                            nb.min_x = nb.max_x;
                        end
                        2: begin
                            nb.min_y = ref_box.max_y + $urandom_range(0, 1);
                            nb.max_y = nb.min_y;
                        end
                        default: begin
                            nb.max_y = ref_box.min_y - $urandom_range(0, 1);
                            nb.min_y = nb.max_y;
                        end
                    endcase
                end else begin
                    nb = random_box(span_log);
                end
                it.box = nb;
                if (n == 0)
                    it.frame_start = ($urandom_range(0, 19) != 0);
                else
                    it.frame_start = ($urandom_range(0, 29) == 0);
                pending_boxes = {pending_boxes, it};
                gen_frame     = {gen_frame, nb};
            end
        end
        boxes_total = pending_boxes.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (boxes_accepted < boxes_total)
            @(posedge i_clk);
        while (expected_pairs.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Input driver: predict on accept, then load the next box or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_pairs(i_frame_start, {i_min_x, i_min_y, i_max_x, i_max_y});
                boxes_accepted++;
            end
            calm = (pending_boxes.size() < CALM_TAIL);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_boxes.size() > 0) begin
                    next_box = pending_boxes.pop_front();
                    i_frame_start <= next_box.frame_start;
                    i_min_x       <= next_box.box.min_x;
                    i_min_y       <= next_box.box.min_y;
                    i_max_x       <= next_box.box.max_x;
                    i_max_y       <= next_box.box.max_y;
                    i_in_valid    <= 1'b1;
                    // change the idle density every few dozen boxes
                    if (boxes_loaded % 40 == 0) begin
                        case ($urandom_range(0, 2))
                            0:       idle_odds = 0;
                            1:       idle_odds = 15;
                            default: idle_odds = 35;
                        endcase
                    end
                    boxes_loaded++;
                    if (!calm && $urandom_range(0, 99) < idle_odds)
                        in_gap = $urandom_range(1, 4);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: random bursts, none in the tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < idle_odds) begin
            out_hold = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Pair monitor: compare each accepted transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pairs.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected pair new %0d old %0d last %0b",
                         $time, o_new_index, o_old_index, o_last_pair);
            end else begin
                oldest_pair = expected_pairs.pop_front();
                if (o_new_index !== oldest_pair.new_index) begin
                    mismatch_count++;
                    $display("%0t: new_index expected %0d actual %0d",
                             $time, oldest_pair.new_index, o_new_index);
                end
                if (o_old_index !== oldest_pair.old_index) begin
                    mismatch_count++;
                    $display("%0t: old_index expected %0d actual %0d",
                             $time, oldest_pair.old_index, o_old_index);
                end
                if (o_last_pair !== oldest_pair.last_pair) begin
                    mismatch_count++;
                    $display("%0t: last_pair expected %0b actual %0b",
                             $time, oldest_pair.last_pair, o_last_pair);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
design/apof_pkg.sv
design/apof_ram.sv
design/aabb_pair_overlap_finder.sv
tb/tb_top.sv
